[sv/msort_pkg.sv]
// Package for the merge sorter: shared constants, controller states and the
// command and status structs that join the controller to the datapath.
// Depends on nothing; the controller, the datapath and the top level import it.
package msort_pkg;

  // Default capacity of the element store and width of one element.
  localparam int unsigned MaxItemsDef = 64;
  localparam int unsigned DataW       = 32;

  // Controller states.
  typedef enum logic [2:0] {
    StIdle,
    StSetup,
    StRead,
    StWrite,
    StEmit
  } msort_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // store the accepted request, or flag it as dropped
    logic init;   // prepare the first merge pass
    logic step;   // place one element of the current merge
    logic emit;   // read out one sorted element
  } msort_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic single;     // only one element is held, no pass is needed
    logic sort_done;  // this step places the final element of the final pass
    logic emit_last;  // this read-out is the final element
  } msort_sts_t;

endpackage

[sv/msort_ctrl.sv]
// Controller state machine of the merge sorter: loads, merge passes, read-out.
// Depends on msort_pkg; drives the datapath in msort_dp by command structs.
module msort_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 last_i,
  input  msort_pkg::msort_sts_t sts_i,
  output msort_pkg::msort_cmd_t cmd_o,
  output logic                 busy_o
);
  import msort_pkg::*;

  msort_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      StIdle: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (last_i) begin
            state_d = StSetup;
          end
        end
      end
      StSetup: begin
        cmd_o.init = 1'b1;
        state_d    = sts_i.single ? StEmit : StRead;
      end
      StRead: begin
        // The datapath fetches both run heads in this cycle.
        state_d = StWrite;
      end
      StWrite: begin
        cmd_o.step = 1'b1;
        state_d    = sts_i.sort_done ? StEmit : StRead;
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        if (sts_i.emit_last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

[sv/msort_dp.sv]
// Datapath of the merge sorter: two ping-pong element memories, run pointers,
// the compare-and-select of one merge step and the result registers.
// Depends on msort_pkg; commanded by msort_ctrl.
module msort_dp #(
  parameter int unsigned MAX_ITEMS = msort_pkg::MaxItemsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  msort_pkg::msort_cmd_t             cmd_i,
  output msort_pkg::msort_sts_t             sts_o,
  input  logic signed [msort_pkg::DataW-1:0] value_i,
  output logic                              valid_o,
  output logic signed [msort_pkg::DataW-1:0] sorted_value_o,
  output logic                              final_res_o,
  output logic                              overflowed_o
);
  import msort_pkg::*;

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned SW = AW + 2;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_ITEMS);

  // Clamp a run bound to the number of held elements.
  function automatic logic [CW-1:0] clamp_n(input logic [SW-1:0] x,
                                            input logic [CW-1:0] n);
    logic [CW-1:0] r;
    r = (x < {1'b0, n}) ? x[CW-1:0] : n;
    return r;
  endfunction

  logic [DataW-1:0] mem0 [MAX_ITEMS];
  logic [DataW-1:0] mem1 [MAX_ITEMS];
  logic [DataW-1:0] rda0_q, rdb0_q, rda1_q, rdb1_q;

  logic [CW-1:0] count_q, width_q, a_q, b_q, mid_q, hi_q, k_q;
  logic          ovf_q, src_q;
  logic          valid_q, final_q, ovf_out_q;

  logic [DataW-1:0] rd_a, rd_b, take_val;
  logic [CW-1:0]    addr_a, k_inc, w2;
  logic [SW-1:0]    nxt_mid_sum, nxt_hi_sum;
  logic             take_a, run_end, pass_end, sort_done, room;
  logic             we0, we1;
  logic [CW-1:0]    waddr0;
  logic [DataW-1:0] wdata0;

  // Heads of the two runs from the memory that holds the current pass.
  assign rd_a = src_q ? rda1_q : rda0_q;
  assign rd_b = src_q ? rdb1_q : rdb0_q;

  // Merge decision: the left run wins on ties.
  assign take_a   = (a_q < mid_q) &&
                    ((b_q >= hi_q) || ($signed(rd_a) <= $signed(rd_b)));
  assign take_val = take_a ? rd_a : rd_b;

  assign k_inc     = k_q + 1'b1;
  assign w2        = {width_q[CW-2:0], 1'b0};
  assign run_end   = (k_inc == hi_q);
  assign pass_end  = run_end && (hi_q == count_q);
  assign sort_done = pass_end && (w2 >= count_q);
  assign room      = (count_q < MaxCount);

  assign nxt_mid_sum = {1'b0, hi_q} + {1'b0, width_q};
  assign nxt_hi_sum  = {1'b0, hi_q} + {1'b0, w2};

  assign sts_o.single    = (count_q == CW'(1));
  assign sts_o.sort_done = sort_done;
  assign sts_o.emit_last = (k_inc == count_q);

  // Read address of the left port doubles as the read-out address.
  assign addr_a = cmd_i.emit ? k_q : a_q;

  // Write ports: loads go to the first memory, merges to the other side.
  assign we0    = (cmd_i.load && room) || (cmd_i.step && src_q);
  assign we1    = cmd_i.step && !src_q;
  assign waddr0 = cmd_i.load ? count_q : k_q;
  assign wdata0 = cmd_i.load ? value_i : take_val;

  // Memories with registered reads.
  always_ff @(posedge clk_i) begin
    if (we0) begin
      mem0[waddr0[AW-1:0]] <= wdata0;
    end
    if (we1) begin
      mem1[k_q[AW-1:0]] <= take_val;
    end
    rda0_q <= mem0[addr_a[AW-1:0]];
    rdb0_q <= mem0[b_q[AW-1:0]];
    rda1_q <= mem1[addr_a[AW-1:0]];
    rdb1_q <= mem1[b_q[AW-1:0]];
  end

  // Fill count, overflow flag and merge pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      width_q <= '0;
      a_q     <= '0;
      b_q     <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      k_q     <= '0;
      src_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (room) begin
          count_q <= count_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.init) begin
        width_q <= CW'(1);
        a_q     <= '0;
        k_q     <= '0;
        mid_q   <= clamp_n(SW'(1), count_q);
        b_q     <= clamp_n(SW'(1), count_q);
        hi_q    <= clamp_n(SW'(2), count_q);
        src_q   <= 1'b0;
      end
      if (cmd_i.step) begin
        if (sort_done) begin
          src_q <= !src_q;
          k_q   <= '0;
        end else if (pass_end) begin
          // Start the next pass with runs of twice the width.
          src_q   <= !src_q;
          width_q <= w2;
          k_q     <= '0;
          a_q     <= '0;
          mid_q   <= clamp_n({1'b0, w2}, count_q);
          b_q     <= clamp_n({1'b0, w2}, count_q);
          hi_q    <= clamp_n({w2, 1'b0}, count_q);
        end else if (run_end) begin
          // Move on to the next pair of runs in this pass.
          k_q   <= k_inc;
          a_q   <= hi_q;
          mid_q <= clamp_n(nxt_mid_sum, count_q);
          b_q   <= clamp_n(nxt_mid_sum, count_q);
          hi_q  <= clamp_n(nxt_hi_sum, count_q);
        end else begin
          k_q <= k_inc;
          if (take_a) begin
            a_q <= a_q + 1'b1;
          end else begin
            b_q <= b_q + 1'b1;
          end
        end
      end
      if (cmd_i.emit) begin
        k_q <= k_inc;
        if (sts_o.emit_last) begin
          count_q <= '0;
          ovf_q   <= 1'b0;
        end
      end
    end
  end

  // Result strobe and markers, aligned with the registered read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      final_q   <= 1'b0;
      ovf_out_q <= 1'b0;
    end else begin
      valid_q   <= cmd_i.emit;
      final_q   <= cmd_i.emit && sts_o.emit_last;
      ovf_out_q <= ovf_q;
    end
  end

  assign valid_o        = valid_q;
  assign final_res_o    = final_q;
  assign overflowed_o   = ovf_out_q;
  assign sorted_value_o = rd_a;

endmodule

[sv/merge_sorter_unit.sv]
// Top level of the merge sorter: joins the controller and the datapath.
// Depends on msort_pkg, msort_ctrl and msort_dp.
//
//   Channel  | Handshake              | Payload
//   ---------+------------------------+------------------------------------------
//   request  | start_i high, busy_o low | value_i, last_i
//   result   | valid_o, one cycle     | sorted_value_o, final_res_o, overflowed_o
//
// A request not marked last is stored, or dropped if the store is full; busy_o stays low.
// After a last request with n held elements the block is busy for a setup step,
// the merge passes and the read-out. Each merge step is a read state, for the
// registered read of both run heads before the compare, then a write state.
// The n results then follow on consecutive cycles; the receiver cannot stall.
// Reset is asynchronous and active low; the element memories are not cleared.
module merge_sorter_unit #(
  parameter int unsigned MAX_ITEMS = msort_pkg::MaxItemsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [msort_pkg::DataW-1:0] value_i,
  input  logic                               last_i,
  output logic                               valid_o,
  output logic signed [msort_pkg::DataW-1:0] sorted_value_o,
  output logic                               final_res_o,
  output logic                               overflowed_o
);
  import msort_pkg::*;

  msort_cmd_t cmd;
  msort_sts_t sts;

  // Sequencer.
  msort_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .last_i  (last_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Storage and merge logic.
  msort_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .value_i        (value_i),
    .valid_o        (valid_o),
    .sorted_value_o (sorted_value_o),
    .final_res_o    (final_res_o),
    .overflowed_o   (overflowed_o)
  );

endmodule

[sv/msort_checker.sv]
// Port-level checker for the merge sorter, bound to merge_sorter_unit.
// Depends only on the top level's ports.
module msort_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic last_i,
  input logic valid_o,
  input logic final_res_o,
  input logic overflowed_o
);

  // The final marker only appears on a result.
  a_final_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_res_o |-> valid_o)
    else $error("final marker without a result");

  // Results of one run come on consecutive cycles.
  a_results_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !final_res_o |=> valid_o)
    else $error("gap inside a sorted run");

  // The overflow marker is the same on every result of a run.
  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !final_res_o |=> overflowed_o == $past(overflowed_o))
    else $error("overflow marker changed within a run");

  // A request not marked last leaves the block ready.
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !last_i |=> !busy_o)
    else $error("busy after a plain load");

  // A last request starts the sort.
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && last_i |=> busy_o)
    else $error("sort not started after a last request");

endmodule

bind merge_sorter_unit msort_checker u_msort_checker (.*);

[verif/tb_merge_sorter_unit.sv]
// Self-checking testbench for merge_sorter_unit: loads sets of signed values,
// predicts the ascending read-out of each set and checks every result strobe.
// Depends on msort_pkg and the merge_sorter_unit RTL.
`timescale 1ns / 100ps

module tb_merge_sorter_unit;

  localparam int Cap        = msort_pkg::MaxItemsDef;
  localparam int DataW      = msort_pkg::DataW;
  localparam int RandomReqs = 185;
  localparam int CalmTail   = 150;
  localparam int DrainCycles = 40;
  localparam int CycleLimit = 200000;

  localparam logic signed [DataW-1:0] MinValue = {1'b1, {(DataW-1){1'b0}}};
  localparam logic signed [DataW-1:0] MaxValue = {1'b0, {(DataW-1){1'b1}}};

  // One expected read-out of a sorted set.
  typedef struct {
    logic signed [DataW-1:0] value;
    logic                    is_final;
    logic                    ovf;
  } sorted_entry_t;

  // Scoreboard: keeps its own copy of the held set and the queue of sorted
  // values still to come out of the block.
  class msort_board;
    logic signed [DataW-1:0] held [Cap];
    int                      held_count;
    bit                      dropped;
    sorted_entry_t           due [$];
    int                      mismatches;
    int                      sets_sorted;
    int                      dropped_sets;
    int                      results_checked;

    function new();
      held_count      = 0;
      dropped         = 1'b0;
      mismatches      = 0;
      sets_sorted     = 0;
      dropped_sets    = 0;
      results_checked = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    // Note an accepted request; a last request turns the held set into
    // expected results.
    function void note_request(input logic signed [DataW-1:0] value, input logic is_last);
      logic signed [DataW-1:0] run [Cap];
      logic signed [DataW-1:0] key;
      sorted_entry_t           entry;
      int                      i;
      int                      j;
      if (held_count < Cap) begin
        held[held_count] = value;
        held_count++;
      end else begin
        dropped = 1'b1;
      end
      if (!is_last) return;
      for (i = 0; i < held_count; i++) run[i] = held[i];
      // Insertion sort with a strict compare, so equal values keep their order.
      for (i = 1; i < held_count; i++) begin
        key = run[i];
        j   = i;
        while (j > 0 && run[j-1] > key) begin
          run[j] = run[j-1];
          j--;
        end
        run[j] = key;
      end
      for (i = 0; i < held_count; i++) begin
        entry.value    = run[i];
        entry.is_final = (i == held_count - 1);
        entry.ovf      = dropped;
        due.push_back(entry);
      end
      sets_sorted++;
      if (dropped) dropped_sets++;
      held_count = 0;
      dropped    = 1'b0;
    endfunction

    // Compare one result strobe with the oldest expected read-out.
    task check_result(input logic signed [DataW-1:0] value, input logic is_final,
                      input logic ovf);
      sorted_entry_t exp_entry;
      results_checked++;
      if (due.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d with nothing pending", value));
      end else begin
        exp_entry = due.pop_front();
        if (value !== exp_entry.value)
          report_mismatch($sformatf("sorted_value_o got %0d, expected %0d",
                                    value, exp_entry.value));
        if (is_final !== exp_entry.is_final)
          report_mismatch($sformatf("final_res_o got %b, expected %b",
                                    is_final, exp_entry.is_final));
        if (ovf !== exp_entry.ovf)
          report_mismatch($sformatf("overflowed_o got %b, expected %b",
                                    ovf, exp_entry.ovf));
      end
    endtask

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic signed [DataW-1:0] value_i;
  logic                    last_i;
  logic                    valid_o;
  logic signed [DataW-1:0] sorted_value_o;
  logic                    final_res_o;
  logic                    overflowed_o;

  msort_board              board;
  int                      cycle_count;
  int                      requests_sent;
  int                      random_sent;
  bit                      idle_on;
  logic signed [DataW-1:0] listed_vals [$];

  merge_sorter_unit #(
    .MAX_ITEMS(Cap)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_i       (value_i),
    .last_i        (last_i),
    .valid_o       (valid_o),
    .sorted_value_o(sorted_value_o),
    .final_res_o   (final_res_o),
    .overflowed_o  (overflowed_o)
  );

  // Clock with an 8 ns period.
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results pending", cycle_count,
               board.pending());
      $display("merge_sorter_unit test failed");
      $finish;
    end
  end

  // Result monitor: every strobe is checked at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      board.check_result(sorted_value_o, final_res_o, overflowed_o);
    end
  end

  // Random value with a bias towards extremes and small repeated values.
  function automatic logic signed [DataW-1:0] pick_value();
    logic signed [DataW-1:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: v = MinValue;
          1: v = MaxValue;
          2: v = '0;
          default: v = -1;
        endcase
      end
      1, 2: v = $signed($urandom_range(0, 8)) - 4;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Present one request, hold it until accepted, then note it.
  task automatic send_request(input logic signed [DataW-1:0] value, input logic is_last);
    int gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 13);
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    value_i <= value;
    last_i  <= is_last;
    do @(posedge clk_i); while (busy_o);
    board.note_request(value, is_last);
    requests_sent++;
  endtask

  // Send the listed values as one set, the final one marked last.
  task automatic send_listed();
    int i;
    for (i = 0; i < listed_vals.size(); i++) begin
      send_request(listed_vals[i], i == listed_vals.size() - 1);
    end
  endtask

  // Send a set of random values of the given size.
  task automatic send_random_set(input int size);
    int i;
    for (i = 0; i < size; i++) begin
      idle_on = idle_on && (random_sent < CalmTail);
      send_request(pick_value(), i == size - 1);
      random_sent++;
    end
  endtask

  initial begin
    int set_no;
    int size;
    board         = new();
    requests_sent = 0;
    random_sent   = 0;
    idle_on       = 1'b0;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    value_i       = '0;
    last_i        = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed sets: a single element, the extremes, ties, short runs and a
    // descending set whose size is not a power of two.
    listed_vals = '{MinValue};
    send_listed();
    listed_vals = '{MaxValue, MinValue, 0, -1, 1};
    send_listed();
    idle_on = 1'b1;
    listed_vals = '{7, -2, 7, -2, 7, 0};
    send_listed();
    listed_vals = '{-5, 9};
    send_listed();
    listed_vals = '{3, -3};
    send_listed();
    idle_on = 1'b0;
    listed_vals = '{7, 6, 5, 4, 3, 2, 1};
    send_listed();

    // Random sets: mostly small, one filling the store exactly and one that
    // overruns it so that the trailing requests are dropped.
    set_no = 0;
    while (random_sent < RandomReqs) begin
      if (set_no == 2) size = Cap;
      else if (set_no == 6) size = Cap + $urandom_range(1, 6);
      else size = $urandom_range(1, 10);
      idle_on = ($urandom_range(0, 2) != 0);
      send_random_set(size);
      set_no++;
    end

    // Let every sorted set drain, then allow time for stray strobes.
    @(negedge clk_i);
    start_i <= 1'b0;
    last_i  <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sorted %0d sets (%0d with dropped requests) from %0d requests;",
             board.sets_sorted, board.dropped_sets, requests_sent);
    $display("checked %0d results, %0d mismatches.", board.results_checked,
             board.mismatches);
    if (board.mismatches == 0) begin
      $display("merge_sorter_unit test passed");
    end else begin
      $display("merge_sorter_unit test failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/msort_pkg.sv
sv/msort_ctrl.sv
sv/msort_dp.sv
sv/merge_sorter_unit.sv
sv/msort_checker.sv
verif/tb_merge_sorter_unit.sv
